// ===== rtl/wmf_pkg.sv =====
package wmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 2;

    localparam int SIDE   = 2 * MAX_RADIUS + 1;
    localparam int WIN_N  = SIDE * SIDE;
    localparam int LINES  = SIDE - 1;

    localparam int VAL_W   = 17;
    localparam int CNT_W   = 21;
    localparam int IDX_W   = 20;
    localparam int DIM_W   = 11;
    localparam int RAD_W   = 2;
    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int THR_W   = $clog2(2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1);
    localparam int RANK_W  = $clog2(WIN_N);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [VAL_W-1:0] ONE_Q16 = VAL_W'(65536);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIAN_RADIUS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RADIUS    = 2'd3;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef logic [VAL_W-1:0] t_val;
    typedef t_val [SIDE-1:0][SIDE-1:0] t_win;
    typedef logic [THR_W-1:0] t_thr;
    typedef t_thr [SIDE-1:0][SIDE-1:0] t_thr_tab;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] p;
        logic             medf;
        logic             outf;
        logic [IDX_W-1:0] q;
        logic             last;
        t_val             v;
    } t_meta;

    typedef struct packed {
        logic [ADDR_W-1:0] wrap;
        logic              w_one;
        logic [RAD_W-1:0]  rm;
        logic [RAD_W-1:0]  rx;
        t_thr_tab          thr;
        logic [RANK_W-1:0] target;
        logic              clr;
        logic [CNT_W-1:0]  npix;
    } t_cfg;

    function automatic logic [RANK_W-1:0] med_target(input logic [RAD_W-1:0] r);
        int s;
        s = 2 * int'(r) + 1;
        return RANK_W'((s * s) >> 1);
    endfunction

endpackage

// ===== rtl/wmf_ram.sv =====
module wmf_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/wmf_front.sv =====
module wmf_front
    import wmf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_func,
    input  logic [VAL_W-1:0]     i_pixel_value,
    input  logic                 i_full,
    output logic                 o_push,
    output t_meta                o_meta,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    logic [DIM_W-1:0] r_width, r_height;
    logic [RAD_W-1:0] r_mrad, r_xrad;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_cfg             r_cfg, n_cfg;

    logic [DIM_W-1:0] w_eff, h_eff;
    logic [RAD_W-1:0] rm_eff, rx_eff;
    logic [CNT_W-1:0] npix, d1, d2, dd, limit, q_full;
    logic             accept;
    t_val             sat;

    always_comb begin
        if (r_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (r_width > DIM_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (r_height > DIM_W'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    assign rm_eff = (r_mrad > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r_mrad;
    assign rx_eff = (r_xrad > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r_xrad;

    assign npix   = CNT_W'(w_eff) * CNT_W'(h_eff);
    assign d1     = CNT_W'(rm_eff) * (CNT_W'(w_eff) + CNT_W'(1));
    assign d2     = CNT_W'(rx_eff) * (CNT_W'(w_eff) + CNT_W'(1));
    assign dd     = d1 + d2;
    assign limit  = npix + dd - CNT_W'(1);
    assign q_full = r_cnt - dd;

    assign accept = i_valid && !i_full;
    assign o_push = accept;
    assign sat    = (i_pixel_value > ONE_Q16) ? ONE_Q16 : i_pixel_value;

    always_comb begin
        o_meta.n    = r_cnt;
        o_meta.p    = r_cnt - d1;
        o_meta.medf = (r_cnt >= d1);
        o_meta.outf = (r_cnt >= dd) && (q_full < npix);
        o_meta.q    = q_full[IDX_W-1:0];
        o_meta.last = (r_cnt == limit);
        o_meta.v    = (i_func == FUNC_PIXEL && r_cnt < npix) ? sat : '0;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_cfg_valid) begin
            n_cnt = '0;
        end else if (accept) begin
            n_cnt = o_meta.last ? '0 : r_cnt + CNT_W'(1);
        end
    end

    always_comb begin
        n_cfg.wrap   = (w_eff < DIM_W'(2)) ? '0 : ADDR_W'(w_eff - DIM_W'(2));
        n_cfg.w_one  = (w_eff == DIM_W'(1));
        n_cfg.rm     = rm_eff;
        n_cfg.rx     = rx_eff;
        n_cfg.target = med_target(rm_eff);
        n_cfg.clr    = i_cfg_valid;
        n_cfg.npix   = npix;
        for (int k = 0; k < SIDE; k++) begin
            for (int j = 0; j < SIDE; j++) begin
                n_cfg.thr[k][j] = THR_W'(k) * THR_W'(w_eff) + THR_W'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1024);
            r_height <= DIM_W'(1024);
            r_mrad   <= RAD_W'(2);
            r_xrad   <= RAD_W'(0);
            r_cnt    <= '0;
            r_cfg    <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_cfg <= n_cfg;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:   r_width  <= i_cfg_data;
                    CFG_FRAME_HEIGHT:  r_height <= i_cfg_data;
                    CFG_MEDIAN_RADIUS: r_mrad   <= i_cfg_data[RAD_W-1:0];
                    CFG_MAX_RADIUS:    r_xrad   <= i_cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/wmf_queue.sv =====
module wmf_queue
    import wmf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_meta i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_meta o_data
);

    t_meta             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/wmf_linebuf.sv =====
module wmf_linebuf
    import wmf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_val              i_din,
    input  logic [ADDR_W-1:0] i_wrap,
    input  logic              i_w_one,
    input  logic              i_clr,
    output t_win              o_win
);

    t_val              r_col0;
    t_val              r_byp [LINES];
    t_val              rd    [LINES];
    t_val              col   [SIDE];
    t_val              r_h   [SIDE][1:SIDE-1];
    logic [ADDR_W-1:0] r_ptr;

    always_comb begin
        col[0] = r_col0;
        for (int k = 0; k < LINES; k++) begin
            col[k+1] = i_w_one ? r_byp[k] : rd[k];
        end
    end

    for (genvar k = 0; k < LINES; k++) begin : g_line
        wmf_ram #(
            .WIDTH (VAL_W),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_adv),
            .i_waddr (r_ptr),
            .i_wdata (col[k]),
            .i_re    (i_adv),
            .i_raddr (r_ptr),
            .o_rdata (rd[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_ptr <= '0;
        end else if (i_adv) begin
            r_ptr <= (r_ptr == i_wrap) ? '0 : r_ptr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_col0 <= i_din;
            for (int k = 0; k < LINES; k++) begin
                r_byp[k] <= col[k];
            end
            for (int k = 0; k < SIDE; k++) begin
                r_h[k][1] <= col[k];
                for (int j = 2; j < SIDE; j++) begin
                    r_h[k][j] <= r_h[k][j-1];
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < SIDE; k++) begin
            o_win[k][0] = col[k];
            for (int j = 1; j < SIDE; j++) begin
                o_win[k][j] = r_h[k][j];
            end
        end
    end

endmodule

// ===== rtl/wmf_back.sv =====
module wmf_back
    import wmf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_qvalid,
    input  t_meta            i_qdata,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [VAL_W-1:0] o_filtered_value,
    output logic [IDX_W-1:0] o_pixel_index,
    output logic             o_frame_end
);

    logic en, adv_x;
    t_win win_m, win_x;
    logic [RAD_W:0] span_m, span_x;

    logic  r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_m_valid;
    logic  r_x_valid, r_y_valid, r_z_valid, r_ov;
    t_meta r_a, r_b, r_c, r_d, r_m, r_x, r_y, r_z;

    t_val             b_val [WIN_N];
    logic [WIN_N-1:0] b_use;
    t_val             r_b_val [WIN_N];
    logic [WIN_N-1:0] r_b_use;

    logic [WIN_N-1:0] c_beat [WIN_N];
    logic [WIN_N-1:0] r_c_beat [WIN_N];
    t_val             r_c_val [WIN_N];
    logic [WIN_N-1:0] r_c_use;

    logic [WIN_N-1:0] d_sel;
    logic [WIN_N-1:0] r_d_sel;
    t_val             r_d_val [WIN_N];

    t_val med;
    t_val r_m_val;

    t_val y_val [SIDE][SIDE];
    t_val r_y_val [SIDE][SIDE];
    t_val z_row [SIDE];
    t_val r_z_row [SIDE];
    t_val z_max;

    t_val             r_oval;
    logic [IDX_W-1:0] r_oidx;
    logic             r_olast;

    assign en     = !r_ov || !i_stall;
    assign o_pop  = en && i_qvalid;
    assign adv_x  = en && r_m_valid && r_m.medf;
    assign span_m = {i_cfg.rm, 1'b0};
    assign span_x = {i_cfg.rx, 1'b0};

    wmf_linebuf u_med_lines (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (o_pop),
        .i_din   (i_qdata.v),
        .i_wrap  (i_cfg.wrap),
        .i_w_one (i_cfg.w_one),
        .i_clr   (i_cfg.clr),
        .o_win   (win_m)
    );

    wmf_linebuf u_max_lines (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv_x),
        .i_din   (r_m_val),
        .i_wrap  (i_cfg.wrap),
        .i_w_one (i_cfg.w_one),
        .i_clr   (i_cfg.clr),
        .o_win   (win_x)
    );

    always_comb begin
        for (int k = 0; k < SIDE; k++) begin
            for (int j = 0; j < SIDE; j++) begin
                b_use[k*SIDE+j] = ((RAD_W+1)'(k) <= span_m) && ((RAD_W+1)'(j) <= span_m);
                b_val[k*SIDE+j] = (r_a.n >= CNT_W'(i_cfg.thr[k][j])) ? win_m[k][j] : '0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WIN_N; i++) begin
            for (int j = 0; j < WIN_N; j++) begin
                c_beat[i][j] = (i != j) && r_b_use[j] &&
                               ((r_b_val[j] < r_b_val[i]) ||
                                (r_b_val[j] == r_b_val[i] && j < i));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WIN_N; i++) begin
            d_sel[i] = r_c_use[i] &&
                       (RANK_W'($countones(r_c_beat[i])) == i_cfg.target);
        end
    end

    always_comb begin
        med = '0;
        for (int i = 0; i < WIN_N; i++) begin
            med = med | (r_d_sel[i] ? r_d_val[i] : '0);
        end
    end

    always_comb begin
        for (int k = 0; k < SIDE; k++) begin
            for (int j = 0; j < SIDE; j++) begin
                y_val[k][j] = ((RAD_W+1)'(k) <= span_x) && ((RAD_W+1)'(j) <= span_x) &&
                              (r_x.p >= CNT_W'(i_cfg.thr[k][j])) ? win_x[k][j] : '0;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < SIDE; k++) begin
            z_row[k] = r_y_val[k][0];
            for (int j = 1; j < SIDE; j++) begin
                if (r_y_val[k][j] > z_row[k]) begin
                    z_row[k] = r_y_val[k][j];
                end
            end
        end
        z_max = r_z_row[0];
        for (int k = 1; k < SIDE; k++) begin
            if (r_z_row[k] > z_max) begin
                z_max = r_z_row[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_x_valid <= 1'b0;
            r_y_valid <= 1'b0;
            r_z_valid <= 1'b0;
            r_ov      <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_qvalid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_m_valid <= r_d_valid;
            r_x_valid <= r_m_valid;
            r_y_valid <= r_x_valid;
            r_z_valid <= r_y_valid;
            r_ov      <= r_z_valid && r_z.outf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a     <= i_qdata;
            r_b     <= r_a;
            r_c     <= r_b;
            r_d     <= r_c;
            r_m     <= r_d;
            r_x     <= r_m;
            r_y     <= r_x;
            r_z     <= r_y;
            r_b_use <= b_use;
            r_c_use <= r_b_use;
            r_d_sel <= d_sel;
            r_m_val <= med;
            for (int i = 0; i < WIN_N; i++) begin
                r_b_val[i]  <= b_val[i];
                r_c_val[i]  <= r_b_val[i];
                r_c_beat[i] <= c_beat[i];
                r_d_val[i]  <= r_c_val[i];
            end
            for (int k = 0; k < SIDE; k++) begin
                r_z_row[k] <= z_row[k];
                for (int j = 0; j < SIDE; j++) begin
                    r_y_val[k][j] <= y_val[k][j];
                end
            end
            r_oval  <= z_max;
            r_oidx  <= r_z.q;
            r_olast <= r_z.last;
        end
    end

    assign o_valid          = r_ov;
    assign o_filtered_value = r_oval;
    assign o_pixel_index    = r_oidx;
    assign o_frame_end      = r_olast;

endmodule

// ===== rtl/window_median_max_filter_core.sv =====
// Streaming median filter followed by an optional max filter over one frame of Q1.16
// weights in raster order. Unless stalled, the block takes one pixel per clock and
// returns one result per clock; pixel n comes out as pixel n - D1 - D2, where D1 =
// median_radius * (frame_width + 1) and D2 = max_radius * (frame_width + 1), so flush
// items must follow the last pixel to drain the frame. Each stage keeps its rows in
// four line RAMs of 1024 words with a 5x5 register window; the median is picked by
// rank counting over the window in four registered steps, and the max by a two-level
// tree in three registered steps. Past the input queue, data runs through registers
// A, B, C, D, M, X, Y, Z and the output register. Taps before the start of the frame
// read zero and taps wrap across row ends. Any configuration write restarts the frame.
module window_median_max_filter_core
    import wmf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_func,
    input  logic [VAL_W-1:0]     i_pixel_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [VAL_W-1:0]     o_filtered_value,
    output logic [IDX_W-1:0]     o_pixel_index,
    output logic                 o_frame_end,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    logic  q_full, q_push, q_pop, q_valid;
    t_meta push_meta, pop_meta;
    t_cfg  cfg;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_full;

    wmf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_func        (i_func),
        .i_pixel_value (i_pixel_value),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_meta        (push_meta),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cfg         (cfg)
    );

    wmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_meta),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (pop_meta)
    );

    wmf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_qvalid         (q_valid),
        .i_qdata          (pop_meta),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_filtered_value (o_filtered_value),
        .o_pixel_index    (o_pixel_index),
        .o_frame_end      (o_frame_end)
    );

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_pixel_index == IDX_W'(cfg.npix - CNT_W'(1)))
        else $error("frame end on wrong pixel");

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_filtered_value <= ONE_Q16)
        else $error("filtered value above one");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> CNT_W'(o_pixel_index) < cfg.npix)
        else $error("pixel index outside frame");

endmodule

// ===== sim/tb_window_median_max_filter_core.sv =====
`timescale 1ns / 100ps

module tb_window_median_max_filter_core;
    import wmf_pkg::*;

    localparam int STORE_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
        logic             last;
    } t_pixel_out;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_func;
    logic [VAL_W-1:0]     i_pixel_value;
    logic                 o_valid;
    logic                 i_stall;
    logic [VAL_W-1:0]     o_filtered_value;
    logic [IDX_W-1:0]     o_pixel_index;
    logic                 o_frame_end;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;

    // filter model state
    int unsigned cfg_width;
    int unsigned cfg_height;
    int unsigned cfg_med_rad;
    int unsigned cfg_max_rad;
    int unsigned median_store [STORE_DEPTH];
    int unsigned peak_store [STORE_DEPTH];
    int          next_index;

    t_pixel_out  pending_pixels [$];
    int          error_count;
    int          items_sent;
    int          pixels_checked;
    int          frames_done;
    int          idle_pct;
    int          stall_pct;
    int          hold_cycles;

    window_median_max_filter_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_pixel_value    (i_pixel_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_filtered_value (o_filtered_value),
        .o_pixel_index    (o_pixel_index),
        .o_frame_end      (o_frame_end),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    function automatic int eff_dim(int unsigned raw, int unsigned lim);
        if (raw == 0) return 1;
        if (raw > lim) return lim;
        return raw;
    endfunction

    function automatic int eff_rad(int unsigned raw);
        return (raw > MAX_RADIUS) ? MAX_RADIUS : raw;
    endfunction

    function automatic int unsigned store_tap(bit from_peak, int idx, int npix);
        if (idx < 0 || idx >= npix) return 0;
        return from_peak ? peak_store[idx % STORE_DEPTH] : median_store[idx % STORE_DEPTH];
    endfunction

    function automatic int unsigned window_median(int p, int w, int r, int npix);
        int unsigned win [WIN_N];
        int unsigned v;
        int n;
        int k;
        n = 0;
        for (int dx = -r; dx <= r; dx++) begin
            for (int dy = -r; dy <= r; dy++) begin
                v = store_tap(1'b0, p + dy * w + dx, npix);
                k = n;
                while (k > 0 && win[k-1] > v) begin
                    win[k] = win[k-1];
                    k--;
                end
                win[k] = v;
                n++;
            end
        end
        return win[n / 2];
    endfunction

    function automatic int unsigned window_peak(int q, int w, int r, int npix);
        int unsigned best;
        int unsigned v;
        best = 0;
        for (int dx = -r; dx <= r; dx++) begin
            for (int dy = -r; dy <= r; dy++) begin
                v = store_tap(1'b1, q + dy * w + dx, npix);
                if (v > best) best = v;
            end
        end
        return best;
    endfunction

    task automatic filter_accept(logic func, logic [VAL_W-1:0] pix);
        int w;
        int npix;
        int rm;
        int rx;
        int n;
        int p;
        int q;
        int unsigned v;
        int unsigned med;
        t_pixel_out res;
        w = eff_dim(cfg_width, MAX_WIDTH);
        npix = w * eff_dim(cfg_height, MAX_HEIGHT);
        rm = eff_rad(cfg_med_rad);
        rx = eff_rad(cfg_max_rad);
        n = next_index;
        v = 0;
        if (func == FUNC_PIXEL && n < npix) begin
            v = pix;
            if (v > ONE_Q16) v = ONE_Q16;
        end
        median_store[n % STORE_DEPTH] = v;
        next_index = n + 1;
        p = n - rm * (w + 1);
        if (p < 0) return;
        med = window_median(p, w, rm, npix);
        peak_store[p % STORE_DEPTH] = med;
        q = p - rx * (w + 1);
        if (q < 0 || q >= npix) return;
        res.value = (rx > 0) ? VAL_W'(window_peak(q, w, rx, npix)) : VAL_W'(med);
        res.index = IDX_W'(q);
        res.last = (q == npix - 1);
        pending_pixels.push_back(res);
        if (res.last) next_index = 0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width = 1024;
            cfg_height = 1024;
            cfg_med_rad = 2;
            cfg_max_rad = 0;
            next_index = 0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                median_store[i] = 0;
                peak_store[i] = 0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:   cfg_width = i_cfg_data;
                    CFG_FRAME_HEIGHT:  cfg_height = i_cfg_data;
                    CFG_MEDIAN_RADIUS: cfg_med_rad = i_cfg_data[1:0];
                    CFG_MAX_RADIUS:    cfg_max_rad = i_cfg_data[1:0];
                    default: ;
                endcase
                next_index = 0;
            end
            if (i_valid && !o_stall) filter_accept(i_func, i_pixel_value);
        end
    end

    always @(posedge i_clk) begin
        t_pixel_out exp_px;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel value %h index %0d end %b", $time,
                         o_filtered_value, o_pixel_index, o_frame_end);
                error_count++;
            end else begin
                exp_px = pending_pixels.pop_front();
                pixels_checked++;
                if (o_filtered_value !== exp_px.value) begin
                    $display("%0t: value expected %h actual %h", $time,
                             exp_px.value, o_filtered_value);
                    error_count++;
                end
                if (o_pixel_index !== exp_px.index) begin
                    $display("%0t: index expected %0d actual %0d", $time,
                             exp_px.index, o_pixel_index);
                    error_count++;
                end
                if (o_frame_end !== exp_px.last) begin
                    $display("%0t: frame end expected %b actual %b", $time,
                             exp_px.last, o_frame_end);
                    error_count++;
                end
                if (exp_px.last) frames_done++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_item(logic func, logic [VAL_W-1:0] pix);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_pixel_value <= pix;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results(bit settle);
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= DIM_W'(data);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] pick_weight();
        case ($urandom_range(7))
            0: return '0;
            1: return ONE_Q16;
            2: return '1;
            3: return VAL_W'($urandom_range(131071, 65537));
            default: return VAL_W'($urandom_range(65536));
        endcase
    endfunction

    // one whole frame plus the padding that drains it
    task automatic run_frame(int unsigned wr, int unsigned hr, int unsigned rmr,
                             int unsigned rxr, int flush_pct);
        int w;
        int npix;
        int tail;
        drain_results(1'b1);
        write_reg(CFG_FRAME_WIDTH, wr);
        write_reg(CFG_FRAME_HEIGHT, hr);
        write_reg(CFG_MEDIAN_RADIUS, rmr);
        write_reg(CFG_MAX_RADIUS, rxr);
        w = eff_dim(wr, MAX_WIDTH);
        npix = w * eff_dim(hr, MAX_HEIGHT);
        tail = (eff_rad(rmr) + eff_rad(rxr)) * (w + 1);
        for (int i = 0; i < npix; i++) begin
            if ($urandom_range(99) < flush_pct) send_item(FUNC_FLUSH, pick_weight());
            else send_item(FUNC_PIXEL, pick_weight());
        end
        for (int i = 0; i < tail; i++) send_item(1'($urandom_range(1)), VAL_W'($urandom));
    endtask

    task automatic set_idling(int sender, int receiver);
        idle_pct = sender;
        stall_pct = receiver;
    endtask

    task automatic test_small_frames();
        set_idling(0, 0);
        run_frame(4, 3, 1, 0, 15);
        run_frame(0, 5, 0, 0, 10);
        run_frame(3, 0, 2, 1, 10);
        run_frame(5, 4, 3, 3, 5);
    endtask

    task automatic test_size_limits();
        set_idling(10, 10);
        run_frame(2047, 1, 0, 0, 2);
        run_frame(1, 1, 2, 2, 2);
    endtask

    task automatic test_back_pressure();
        set_idling(0, 0);
        hold_cycles = 300;
        run_frame(8, 6, 2, 2, 5);
        drain_results(1'b1);
        write_reg(CFG_FRAME_WIDTH, 6);
        write_reg(CFG_MAX_RADIUS, 1);
        for (int i = 0; i < 20; i++) send_item(FUNC_PIXEL, pick_weight());
        drain_results(1'b0);
        for (int i = 0; i < 28 + 14; i++) send_item(FUNC_PIXEL, pick_weight());
    endtask

    task automatic test_random_frames(int target);
        int phase;
        phase = 0;
        while (items_sent < target) begin
            case (phase % 5)
                0: set_idling(0, 0);
                1: set_idling(85, 0);
                2: set_idling(0, 85);
                3: set_idling(10, 10);
                default: set_idling($urandom_range(40), $urandom_range(40));
            endcase
            phase++;
            run_frame($urandom_range(12, 1), $urandom_range(8, 1), $urandom_range(3),
                      $urandom_range(3), $urandom_range(8));
        end
    endtask

    initial begin
        error_count = 0;
        items_sent = 0;
        pixels_checked = 0;
        frames_done = 0;
        hold_cycles = 0;
        set_idling(0, 0);
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = FUNC_PIXEL;
        i_pixel_value = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FRAME_WIDTH;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_small_frames();
        test_back_pressure();
        test_size_limits();
        test_random_frames(1900);
        drain_results(1'b1);
        $display("%0d items sent over %0d frames, %0d filtered pixels compared", items_sent,
                 frames_done, pixels_checked);
        $display("covered radius 0..3 writes, wrapped windows, back-pressure and idle gaps");
        if (error_count == 0 && pending_pixels.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
